[rtl/core/cbet_pkg.sv]
package cbet_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned REC_W    = 11;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned SPAN_W   = 6;
  localparam int unsigned CRCW_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [7:0]        BYTE_MASK = 8'hff;
  localparam logic [SPAN_W-1:0] SPAN_PAD  = 6'd7;

  localparam logic [CRCW_W-1:0] CRC_WIDTH_MIN = 7'd8;
  localparam logic [CRCW_W-1:0] CRC_WIDTH_MAX = 7'd64;
  localparam logic [SPAN_W-1:0] SPAN_MAX      = 6'd32;

  localparam logic [CRCW_W-1:0] CRC_WIDTH_RST = 7'd32;
  localparam logic [SPAN_W-1:0] SPAN_RST      = 6'd11;

  localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CRC_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPAN  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_WALK,
    ST_TRAIL,
    ST_LEAD,
    ST_UNALIGN,
    ST_EMIT,
    ST_NOFIX
  } trap_state_t;

  function automatic logic [WORD_W-1:0] rev64(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] r;
    for (int k = 0; k < WORD_W; k++) begin
      r[k] = v[WORD_W-1-k];
    end
    return r;
  endfunction

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

endpackage

[rtl/core/crc_burst_error_trap.sv]
// Channel  Direction  Handshake            Word carried
// -------  ---------  -------------------  -------------------------------------------
// in_      input      in_valid / in_stall  syndrome_value, record_bytes
// out_     output     out_valid/out_stall  corrected, burst_span, byte_position,
//                                          xor_mask, last_result
// cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data (crc_poly, crc_width,
//                                          max_burst_span)
//
// Sequence: capture, set up, then walk the record a byte at a time through the 8-step
// LFSR byte unit; once trapped, measure the span bit-serially, realign, and emit the
// output words.
// Reset: rst_n is synchronous and active low; it returns the sequencer to idle, drops
// out_valid and loads the register defaults (width 32, span 11, polynomial 0).
// Stalls: in_stall is high whenever an item is in progress. A stalled output word
// holds; emission waits on it, and a fresh item may be taken while it waits.
module crc_burst_error_trap
  import cbet_pkg::*;
#(
  parameter int MAX_RECORD_BYTES = 1024
) (
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [WORD_W-1:0]    in_syndrome_value,
  input  logic [REC_W-1:0]     in_record_bytes,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_corrected,
  output logic [SPAN_W-1:0]    out_burst_span,
  output logic [POS_W-1:0]     out_byte_position,
  output logic [7:0]           out_xor_mask,
  output logic                 out_last_result,

  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  // Record lengths above the cap saturate; the port cannot carry more than 2047.
  localparam logic [REC_W-1:0] REC_CAP =
    (MAX_RECORD_BYTES > 2047) ? {REC_W{1'b1}} : REC_W'(MAX_RECORD_BYTES);

  // configuration registers
  logic [WORD_W-1:0] crc_poly_r;
  logic [CRCW_W-1:0] crc_width_r;
  logic [SPAN_W-1:0] max_span_r;

  // sequencer and working registers
  trap_state_t       state_r, state_nxt;
  logic [WORD_W-1:0] syn_r, syn_nxt;
  logic [REC_W-1:0]  rec_r, rec_nxt;
  logic [REC_W-1:0]  idx_r, idx_nxt;
  logic [WORD_W-1:0] s_r, s_nxt;        // LFSR, held left-aligned while walking
  logic [WORD_W-1:0] p_r, p_nxt;        // reversed polynomial, left-aligned
  logic [WORD_W-1:0] trap_r, trap_nxt;  // bits that must be clear to trap
  logic [WORD_W-1:0] t_r, t_nxt;        // trapped pattern under measurement
  logic [5:0]        shamt_r, shamt_nxt;
  logic [SPAN_W-1:0] bits_r, bits_nxt;
  logic [SPAN_W-1:0] span_r, span_nxt;

  // output word register
  logic              out_valid_r, out_valid_nxt;
  logic              out_corr_r, out_corr_nxt;
  logic [SPAN_W-1:0] out_span_r, out_span_nxt;
  logic [POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [7:0]        out_mask_r, out_mask_nxt;
  logic              out_last_r, out_last_nxt;

  logic in_take;
  logic out_free;
  logic emit_last;

  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_last = (bits_r <= 6'd8) || ((idx_r + 11'd1) == rec_r);

  // --------------------------------------------------------------------------
  // Set-up arithmetic: clamp width and span, align everything to bit 63 so the
  // feedback tap is always the top bit.
  // --------------------------------------------------------------------------
  logic [CRCW_W-1:0] w_eff;
  logic [SPAN_W-1:0] ms_eff;
  logic [CRCW_W-1:0] w_less;
  logic [WORD_W-1:0] wmask;
  logic [6:0]        shamt_full;
  logic [6:0]        trap_sh;

  always_comb begin
    if (crc_width_r < CRC_WIDTH_MIN) begin
      w_eff = CRC_WIDTH_MIN;
    end else if (crc_width_r > CRC_WIDTH_MAX) begin
      w_eff = CRC_WIDTH_MAX;
    end else begin
      w_eff = crc_width_r;
    end
    w_less = w_eff - 7'd1;
    if (max_span_r == '0) begin
      ms_eff = 6'd1;
    end else if (max_span_r > SPAN_MAX) begin
      ms_eff = SPAN_MAX;
    end else begin
      ms_eff = max_span_r;
    end
    if ({1'b0, ms_eff} >= w_eff) begin
      ms_eff = w_less[SPAN_W-1:0];
    end
    shamt_full = CRC_WIDTH_MAX - w_eff;
    wmask      = {WORD_W{1'b1}} >> shamt_full;
    trap_sh    = shamt_full + {1'b0, ms_eff};
  end

  // --------------------------------------------------------------------------
  // Byte unit: eight LFSR steps, noting the first step that traps.
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] v [0:8];
  logic              hit;
  logic [WORD_W-1:0] hit_val;

  always_comb begin
    v[0]    = s_r;
    hit     = 1'b0;
    hit_val = '0;
    for (int b = 0; b < 8; b++) begin
      v[b+1] = v[b][WORD_W-1] ? ((v[b] << 1) ^ p_r) : (v[b] << 1);
      if (!hit && (v[b+1] != '0) && ((v[b+1] & trap_r) == '0)) begin
        hit     = 1'b1;
        hit_val = v[b+1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if ((rev64(syn_r & wmask) == '0) || (rec_r == '0)) begin
          state_nxt = ST_NOFIX;
        end else begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (hit) begin
          state_nxt = ST_TRAIL;
        end else if (idx_r == 11'd1) begin
          state_nxt = ST_NOFIX;
        end
      end
      ST_TRAIL: begin
        if (t_r[0]) begin
          state_nxt = ST_LEAD;
        end
      end
      ST_LEAD: begin
        if (t_r == '0) begin
          state_nxt = ST_UNALIGN;
        end
      end
      ST_UNALIGN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_NOFIX: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and output word
  // --------------------------------------------------------------------------
  always_comb begin
    syn_nxt   = syn_r;
    rec_nxt   = rec_r;
    idx_nxt   = idx_r;
    s_nxt     = s_r;
    p_nxt     = p_r;
    trap_nxt  = trap_r;
    t_nxt     = t_r;
    shamt_nxt = shamt_r;
    bits_nxt  = bits_r;
    span_nxt  = span_r;

    // drop the held word once taken
    out_valid_nxt = out_valid_r && out_stall;
    out_corr_nxt  = out_corr_r;
    out_span_nxt  = out_span_r;
    out_pos_nxt   = out_pos_r;
    out_mask_nxt  = out_mask_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          syn_nxt = in_syndrome_value;
          rec_nxt = (in_record_bytes > REC_CAP) ? REC_CAP : in_record_bytes;
        end
      end
      ST_LOAD: begin
        s_nxt     = rev64(syn_r & wmask);
        p_nxt     = (rev64(crc_poly_r & wmask) << 1) |
                    ({{(WORD_W-1){1'b0}}, 1'b1} << shamt_full);
        trap_nxt  = {WORD_W{1'b1}} << trap_sh;
        shamt_nxt = shamt_full[5:0];
        bits_nxt  = ms_eff + SPAN_PAD;
        idx_nxt   = rec_r;
        span_nxt  = '0;
      end
      ST_WALK: begin
        // finish the whole byte even when the trap lands mid-byte
        s_nxt   = v[8];
        idx_nxt = idx_r - 11'd1;
        if (hit) begin
          t_nxt = hit_val;
        end
      end
      ST_TRAIL: begin
        if (!t_r[0]) begin
          t_nxt = t_r >> 1;
        end
      end
      ST_LEAD: begin
        if (t_r != '0) begin
          t_nxt    = t_r >> 1;
          span_nxt = span_r + 6'd1;
        end
      end
      ST_UNALIGN: begin
        s_nxt = s_r >> shamt_r;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_corr_nxt  = 1'b1;
          out_span_nxt  = span_r;
          out_pos_nxt   = idx_r[POS_W-1:0];
          out_mask_nxt  = rev8(s_r[7:0] & BYTE_MASK);
          out_last_nxt  = emit_last;
          // advance to the next byte of the pattern
          s_nxt         = s_r >> 8;
          idx_nxt       = idx_r + 11'd1;
          bits_nxt      = emit_last ? '0 : (bits_r - 6'd8);
        end
      end
      ST_NOFIX: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_corr_nxt  = 1'b0;
          out_span_nxt  = '0;
          out_pos_nxt   = '0;
          out_mask_nxt  = '0;
          out_last_nxt  = 1'b1;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      crc_poly_r  <= '0;
      crc_width_r <= CRC_WIDTH_RST;
      max_span_r  <= SPAN_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_CRC_POLY:  crc_poly_r  <= cfg_data;
          REG_CRC_WIDTH: crc_width_r <= cfg_data[CRCW_W-1:0];
          REG_MAX_SPAN:  max_span_r  <= cfg_data[SPAN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    syn_r      <= syn_nxt;
    rec_r      <= rec_nxt;
    idx_r      <= idx_nxt;
    s_r        <= s_nxt;
    p_r        <= p_nxt;
    trap_r     <= trap_nxt;
    t_r        <= t_nxt;
    shamt_r    <= shamt_nxt;
    bits_r     <= bits_nxt;
    span_r     <= span_nxt;
    out_corr_r <= out_corr_nxt;
    out_span_r <= out_span_nxt;
    out_pos_r  <= out_pos_nxt;
    out_mask_r <= out_mask_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_corrected     = out_corr_r;
  assign out_burst_span    = out_span_r;
  assign out_byte_position = out_pos_r;
  assign out_xor_mask      = out_mask_r;
  assign out_last_result   = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |->
      ($past(state_r) == ST_EMIT || $past(state_r) == ST_NOFIX))
    else $error("output word appeared outside an emitting state");

  a_corr_span: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_corr_r) |-> (out_span_r != '0 && out_span_r <= SPAN_MAX))
    else $error("corrected word carries an impossible burst span");

  a_nofix_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_corr_r) |-> (out_last_r && out_mask_r == '0 && out_span_r == '0))
    else $error("uncorrected word is not a lone empty result");

  a_walk_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WALK) |-> (idx_r != '0 && idx_r <= rec_r))
    else $error("byte walk running with an exhausted cursor");

  a_emit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (idx_r < rec_r && bits_r != '0))
    else $error("emission past the record end or the burst");

endmodule
